>>> sv/pat_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the pedal activity tracker
// no dependencies; imported by every module of the block

package pat_pkg;

    // field widths
    localparam int NOW_W     = 32;
    localparam int TICK_W    = 16;
    localparam int REV_W     = 24;
    localparam int CIRC_W    = 12;
    localparam int DIST_W    = 36;
    localparam int SPEED_W   = 32;
    localparam int SESS_W    = 17;
    localparam int CNTR_W    = 16;
    localparam int PER_W     = 16;
    localparam int RTS_W     = 8;

    // speed divide: distance delta times 1000 needs 46 bits
    localparam int DVD_W     = DIST_W + 10;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam logic [DVD_W-1:0] MS_PER_S = DVD_W'(1000);

    // stream words, padded to whole bytes
    localparam int SDATA_W   = 56;
    localparam int MDATA_W   = 120;

    // apb register file
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam logic [2:0] REG_REVS_TO_START  = 3'd0;
    localparam logic [2:0] REG_START_WINDOW   = 3'd1;
    localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_REPORT_PERIOD  = 3'd3;
    localparam logic [2:0] REG_WHEEL_CIRC     = 3'd4;

    // per-tick event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_START   = 2'd1;
    localparam logic [1:0] EV_DISCARD = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [RTS_W-1:0]  revs_to_start;
        logic [NOW_W-1:0]  start_window_ms;
        logic [NOW_W-1:0]  idle_timeout_ms;
        logic [PER_W-1:0]  report_period_ms;
        logic [CIRC_W-1:0] wheel_circumference_mm;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic pulse_upd;
        logic eval;
        logic decide;
        logic scale;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_needed;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> sv/pedal_activity_tracker_unit.sv
`timescale 1ns / 1ps
// pedal activity tracker top level: stream ports, apb register file
// depends on pat_pkg, pat_ctrl and pat_datapath

// Each input word is one polling tick; each tick yields exactly one output word
// carrying the led level, session state, event code, report flag, session number,
// revolutions and distance in mm, and, on report ticks, the speed in mm/s. A tick
// passes through the pulse, eval, decide and scale states to the load state, and
// no new word is taken while a tick is in flight; on a report tick with a positive
// distance delta the speed is computed by a bit-serial divider that takes 46 steps
// before the load. The input is accepted again the cycle after the previous word
// is loaded into the output register, even if it is not yet taken.
// Registers must be written over apb only while no tick is in flight, which the
// block itself does not enforce: revs_to_start at 0x00, start_window_ms at 0x04,
// idle_timeout_ms at 0x08, report_period_ms at 0x0c, wheel_circumference_mm 0x10.

module pedal_activity_tracker_unit
    import pat_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // stream in
    input  logic               s_tvalid,
    output logic               s_tready,
    // now_ms[31:0], tick_ms[47:32], pulse_seen[48], link_up[49], sensor_level[50]
    input  logic [SDATA_W-1:0] s_tdata,
    // stream out
    output logic               m_tvalid,
    input  logic               m_tready,
    // led_on[0], session_active[1], tick_event[3:2], report_valid[4],
    // session_number[21:5], revolution_total[45:22], distance_mm[81:46],
    // speed_mm_s[113:82]
    output logic [MDATA_W-1:0] m_tdata,
    // apb
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[PADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.revs_to_start          <= RTS_W'(3);
            cfg_reg.start_window_ms        <= NOW_W'(10000);
            cfg_reg.idle_timeout_ms        <= NOW_W'(30000);
            cfg_reg.report_period_ms       <= PER_W'(5000);
            cfg_reg.wheel_circumference_mm <= CIRC_W'(2100);
        end else if (wr_en) begin
            unique case (reg_index)
                REG_REVS_TO_START: cfg_reg.revs_to_start <= pwdata[RTS_W-1:0];
                REG_START_WINDOW:  cfg_reg.start_window_ms <= pwdata[NOW_W-1:0];
                REG_IDLE_TIMEOUT:  cfg_reg.idle_timeout_ms <= pwdata[NOW_W-1:0];
                REG_REPORT_PERIOD: cfg_reg.report_period_ms <= pwdata[PER_W-1:0];
                REG_WHEEL_CIRC:    cfg_reg.wheel_circumference_mm <= pwdata[CIRC_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_index)
            REG_REVS_TO_START: prdata = {(PDATA_W - RTS_W)'(0), cfg_reg.revs_to_start};
            REG_START_WINDOW:  prdata = cfg_reg.start_window_ms;
            REG_IDLE_TIMEOUT:  prdata = cfg_reg.idle_timeout_ms;
            REG_REPORT_PERIOD: prdata = {(PDATA_W - PER_W)'(0), cfg_reg.report_period_ms};
            REG_WHEEL_CIRC:
                prdata = {(PDATA_W - CIRC_W)'(0), cfg_reg.wheel_circumference_mm};
            default:           prdata = '0;
        endcase
    end

    pat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pat_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sv/pat_div.sv
`timescale 1ns / 1ps
// restoring divider for the speed figure, one quotient bit per cycle
// depends on pat_pkg

module pat_div
    import pat_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [PER_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    logic [DVD_W-1:0]     q_reg;
    logic [PER_W-1:0]     rem_reg;
    logic [PER_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [PER_W:0]       rem_shift;
    logic                 fits;

    // trial subtract of the shifted remainder
    assign rem_shift = {rem_reg, q_reg[DVD_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    // control: busy flag, step counter, done flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[DVD_W-2:0], fits};
            if (fits) begin
                rem_reg <= PER_W'(rem_shift - {1'b0, dsr_reg});
            end else begin
                rem_reg <= rem_shift[PER_W-1:0];
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

>>> sv/pat_datapath.sv
`timescale 1ns / 1ps
// tracker datapath: session state, tick evaluation, report math, output word
// depends on pat_pkg and pat_div

module pat_datapath
    import pat_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic [SDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata
);

    // input word
    logic [NOW_W-1:0]  now_reg;
    logic [TICK_W-1:0] tick_reg;
    logic              pulse_reg;
    logic              link_reg;
    logic              level_reg;

    // session state
    logic                     active_reg;
    logic [REV_W-1:0]         rev_reg;
    logic [NOW_W-1:0]         first_reg;
    logic [NOW_W-1:0]         last_reg;
    logic [NOW_W-1:0]         timer_reg;
    logic [DIST_W-1:0]        prev_reg;
    logic signed [SESS_W-1:0] session_reg;
    logic [CNTR_W-1:0]        counter_reg;

    // evaluation results
    logic              win_ok_reg;
    logic              rev_ok_reg;
    logic              timeout_reg;
    logic [NOW_W-1:0]  timer_plus_reg;
    logic [DIST_W-1:0] prod_reg;

    // decision results
    logic              div_needed_reg;
    logic [DIST_W-1:0] diff_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [1:0]        event_reg;
    logic              report_reg;
    logic [DVD_W-1:0]  dividend_reg;

    // output word
    logic                     m_tvalid_reg;
    logic                     out_led_reg;
    logic                     out_active_reg;
    logic [1:0]               out_event_reg;
    logic                     out_report_reg;
    logic signed [SESS_W-1:0] out_session_reg;
    logic [REV_W-1:0]         out_rev_reg;
    logic [DIST_W-1:0]        out_dist_reg;
    logic [SPEED_W-1:0]       out_speed_reg;

    // evaluation logic
    logic [NOW_W-1:0]  since_first;
    logic [NOW_W-1:0]  since_last;
    logic [NOW_W:0]    timer_sum;

    // decision logic
    logic                     active_next;
    logic [REV_W-1:0]         rev_next;
    logic [NOW_W-1:0]         first_next;
    logic [NOW_W-1:0]         last_next;
    logic [NOW_W-1:0]         timer_next;
    logic [DIST_W-1:0]        prev_next;
    logic signed [SESS_W-1:0] session_next;
    logic [CNTR_W-1:0]        counter_next;
    logic [1:0]               event_next;
    logic                     report_next;
    logic                     div_needed_next;
    logic [DIST_W-1:0]        diff_next;
    logic [DIST_W-1:0]        dist_next;
    logic                     cleared;
    logic [NOW_W-1:0]         timer_new;
    logic [DIST_W-1:0]        total;
    logic [DIST_W-1:0]        prev_eff;

    // divider hookup
    logic [PER_W-1:0]   divisor;
    logic [DVD_W-1:0]   quotient;
    logic               div_done;
    logic [SPEED_W-1:0] speed;

    // capture the input word
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg   <= s_tdata[31:0];
            tick_reg  <= s_tdata[47:32];
            pulse_reg <= s_tdata[48];
            link_reg  <= s_tdata[49];
            level_reg <= s_tdata[50];
        end
    end

    // elapsed times, start and timeout tests, report timer sum, distance product
    assign since_first = now_reg - first_reg;
    assign since_last  = now_reg - last_reg;
    assign timer_sum   = {1'b0, timer_reg} + {(NOW_W + 1 - TICK_W)'(0), tick_reg};

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            win_ok_reg     <= since_first <= cfg.start_window_ms;
            rev_ok_reg     <= rev_reg >= {(REV_W - RTS_W)'(0), cfg.revs_to_start};
            timeout_reg    <= since_last >= cfg.idle_timeout_ms;
            timer_plus_reg <= timer_sum[NOW_W] ? '1 : timer_sum[NOW_W-1:0];
            prod_reg       <= {(DIST_W - REV_W)'(0), rev_reg}
                              * {(DIST_W - CIRC_W)'(0), cfg.wheel_circumference_mm};
        end
    end

    // session decision for this tick
    always_comb begin
        active_next     = active_reg;
        rev_next        = rev_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        timer_next      = timer_reg;
        prev_next       = prev_reg;
        session_next    = session_reg;
        counter_next    = counter_reg;
        event_next      = EV_NONE;
        report_next     = 1'b0;
        div_needed_next = 1'b0;
        diff_next       = diff_reg;
        cleared         = 1'b0;
        timer_new       = timeout_reg ? {(NOW_W - TICK_W)'(0), tick_reg} : timer_plus_reg;
        total           = timeout_reg ? '0 : prod_reg;
        prev_eff        = timeout_reg ? '0 : prev_reg;

        if (!active_reg) begin
            if (rev_ok_reg && win_ok_reg) begin
                active_next  = 1'b1;
                session_next = $signed({1'b0, counter_reg});
                counter_next = counter_reg + 1'b1;
                event_next   = EV_START;
            end else if (!win_ok_reg && rev_reg != '0) begin
                cleared    = 1'b1;
                event_next = EV_DISCARD;
            end
        end else begin
            if (timeout_reg) begin
                cleared    = 1'b1;
                event_next = EV_TIMEOUT;
            end
        end

        // clear the attempt or session
        if (cleared) begin
            active_next  = 1'b0;
            rev_next     = '0;
            first_next   = '0;
            last_next    = '0;
            timer_next   = '0;
            prev_next    = '0;
            session_next = '1;
        end

        // report timer still runs on a timeout tick
        if (active_reg) begin
            if (timer_new >= {(NOW_W - PER_W)'(0), cfg.report_period_ms}) begin
                timer_next = '0;
                if (link_reg) begin
                    if (total > prev_eff) begin
                        div_needed_next = 1'b1;
                        diff_next       = total - prev_eff;
                    end
                    prev_next   = total;
                    report_next = 1'b1;
                end
            end else begin
                timer_next = timer_new;
            end
        end

        dist_next = cleared ? '0 : prod_reg;
    end

    // session state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            rev_reg     <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            timer_reg   <= '0;
            prev_reg    <= '0;
            session_reg <= '1;
            counter_reg <= '0;
        end else if (cmd.pulse_upd) begin
            if (pulse_reg) begin
                last_reg <= now_reg;
                if (rev_reg == '0) begin
                    first_reg <= now_reg;
                end
                if (rev_reg != '1) begin
                    rev_reg <= rev_reg + 1'b1;
                end
            end
        end else if (cmd.decide) begin
            active_reg  <= active_next;
            rev_reg     <= rev_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            timer_reg   <= timer_next;
            prev_reg    <= prev_next;
            session_reg <= session_next;
            counter_reg <= counter_next;
        end
    end

    // per-tick decision results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_needed_reg <= 1'b0;
        end else if (cmd.decide) begin
            div_needed_reg <= div_needed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            diff_reg   <= diff_next;
            dist_reg   <= dist_next;
            event_reg  <= event_next;
            report_reg <= report_next;
        end
    end

    // distance delta scaled to mm/s numerator
    always_ff @(posedge aclk) begin
        if (cmd.scale) begin
            dividend_reg <= {(DVD_W - DIST_W)'(0), diff_reg} * MS_PER_S;
        end
    end

    // a zero period divides by one
    assign divisor = (cfg.report_period_ms == '0) ? PER_W'(1) : cfg.report_period_ms;

    pat_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend_reg),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    // saturate the quotient to 32 bits; zero when no speed is pending
    always_comb begin
        if (!div_needed_reg) begin
            speed = '0;
        end else if (quotient[DVD_W-1:SPEED_W] != '0) begin
            speed = '1;
        end else begin
            speed = quotient[SPEED_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_led_reg     <= ~level_reg;
            out_active_reg  <= active_reg;
            out_event_reg   <= event_reg;
            out_report_reg  <= report_reg;
            out_session_reg <= session_reg;
            out_rev_reg     <= rev_reg;
            out_dist_reg    <= dist_reg;
            out_speed_reg   <= speed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_speed_reg, out_dist_reg, out_rev_reg, out_session_reg,
                       out_report_reg, out_event_reg, out_active_reg, out_led_reg};

    assign status.div_needed = div_needed_reg;
    assign status.div_done   = div_done;
    assign status.out_free   = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    // a running session always carries a real session number
    a_active_has_session: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> !session_reg[SESS_W-1])
        else $error("active session without a session number");

    // with no revolutions counted the pulse times are cleared
    a_no_revs_no_times: assert property (@(posedge aclk) disable iff (!aresetn)
        (rev_reg == '0) |-> (first_reg == '0 && last_reg == '0))
        else $error("pulse times held with zero revolutions");

    // a nonzero speed only travels with a report
    a_speed_needs_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_speed_reg != '0) |-> out_report_reg)
        else $error("speed reported without report flag");

    // the divider starts only for a report with a positive delta
    a_div_start_needed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> div_needed_reg)
        else $error("divider started without a pending speed");
`endif

endmodule

>>> sv/pat_ctrl.sv
`timescale 1ns / 1ps
// tracker controller: sequences one tick through the datapath
// depends on pat_pkg

module pat_ctrl
    import pat_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PULSE    = 3'd1;
    localparam logic [2:0] S_EVAL     = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SCALE    = 3'd4;
    localparam logic [2:0] S_DIV_GO   = 3'd5;
    localparam logic [2:0] S_DIV_WAIT = 3'd6;
    localparam logic [2:0] S_LOAD     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_PULSE;
                end
            end
            S_PULSE: begin
                cmd.pulse_upd = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = status.div_needed ? S_DIV_GO : S_LOAD;
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule
